// ----- rtl/raa_pkg.sv -----
// ----------------------------------------------------------------------------
// Rectangle atlas allocator package
// Shared widths, item types, status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package raa_pkg;

  localparam int MAX_RECTS  = 256;
  localparam int COORD_BITS = 14;
  localparam int POS_BITS   = 13;
  localparam int IDX_BITS   = $clog2(MAX_RECTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  // Signed working width for candidate corners and their far edges.
  localparam int EXT_BITS   = COORD_BITS + 4;
  localparam int CAND_BITS  = 3;

  localparam logic [COORD_BITS-1:0] SIDE_RESET = COORD_BITS'(1024);

  // Result status codes.
  localparam logic [1:0] STAT_PLACED = 2'd0;
  localparam logic [1:0] STAT_NO_FIT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // Candidate corner codes, tried in this order around each anchor.
  localparam logic [CAND_BITS-1:0] CAND_RIGHT       = 3'd0;
  localparam logic [CAND_BITS-1:0] CAND_BELOW       = 3'd1;
  localparam logic [CAND_BITS-1:0] CAND_LEFT_TOP    = 3'd2;
  localparam logic [CAND_BITS-1:0] CAND_LEFT_BOT    = 3'd3;
  localparam logic [CAND_BITS-1:0] CAND_ABOVE_RIGHT = 3'd4;
  localparam logic [CAND_BITS-1:0] CAND_ABOVE_LEFT  = 3'd5;

  typedef logic signed [EXT_BITS-1:0] ext_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] req_width;
    logic [COORD_BITS-1:0] req_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
  } out_item_t;

  // One table entry: position and unpadded size; padding is added on read.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic       accept;
    logic       clr_cand;
    logic       rd_anchor;
    logic       ld_anchor;
    logic       ld_cand;
    logic       rd_scan;
    logic       j_clr;
    logic       j_inc;
    logic       k_inc;
    logic       i_clr;
    logic       i_inc;
    logic       store;
    logic       set_res;
    logic [1:0] res_code;
    logic       push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic bound_ok;
    logic overlap;
    logic k_last;
    logic i_last;
    logic j_last;
    logic out_busy;
  } dp_status_t;

  function automatic ext_t to_ext(input logic [COORD_BITS-1:0] v);
    return ext_t'({{(EXT_BITS-COORD_BITS){1'b0}}, v});
  endfunction

endpackage

// ----- rtl/rect_atlas_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Rectangle atlas allocator core
// Places requested rectangles in a square atlas and reports their corners.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   -------  ---------  ------------------  ---------------------------------
//   in_      input      in_valid/in_stall   in_item_t: req_width, req_height
//   out_     output     out_valid/out_stall out_item_t: status, pos_x, pos_y
//   cfg_     input      cfg_valid/cfg_ready atlas_side (14 bits)
//
// One item is processed at a time. A request on a full table or on an empty
// table goes straight to its result. Otherwise each anchor is read from the
// table, and each of its six candidates is loaded, bounds checked and advanced,
// with one table read and compare per entry scanned, so the worst-case search
// grows with the square of the number of stored rectangles.
// The single read port of the rectangle table sets this.
// Reset is synchronous and active low; it empties the table (fill count only,
// no clearing pass) and sets atlas_side to 1024. A stalled result sits in the
// output register while the next item is accepted and worked on.
//
// The controller walks the table in insertion order: every stored rectangle is
// an anchor, and around it six corners are tried in a fixed order. A corner is
// taken when the rectangle lies inside the atlas and strictly overlaps no
// stored rectangle, where each stored rectangle carries one unit of padding on
// its width and height. The very first request is placed at the origin with no
// bounds check. The datapath holds the table, the counters, the candidate
// arithmetic and the output register; the controller only issues commands.
//
module rect_atlas_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  raa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output raa_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [raa_pkg::COORD_BITS-1:0] cfg_data
);

  raa_pkg::ctrl_cmd_t  cmd;
  raa_pkg::dp_status_t st;

  // The configuration register can be written at any cycle.
  assign cfg_ready = 1'b1;

  raa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  raa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- rtl/raa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module raa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/raa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the anchor walk, candidate checks and table scans of one request.
// ----------------------------------------------------------------------------
module raa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  raa_pkg::dp_status_t st,
  output raa_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DISPATCH  = 11'b000_0000_0010,
    ST_ANCHOR_RD = 11'b000_0000_0100,
    ST_ANCHOR_LD = 11'b000_0000_1000,
    ST_CAND      = 11'b000_0001_0000,
    ST_BOUND     = 11'b000_0010_0000,
    ST_SCAN_RD   = 11'b000_0100_0000,
    ST_SCAN_CMP  = 11'b000_1000_0000,
    ST_NEXT      = 11'b001_0000_0000,
    ST_STORE     = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = raa_pkg::STAT_FULL;
          state_nxt    = ST_DONE;
        end else if (st.empty) begin
          cmd.clr_cand = 1'b1;
          state_nxt    = ST_STORE;
        end else begin
          cmd.i_clr = 1'b1;
          state_nxt = ST_ANCHOR_RD;
        end
      end
      ST_ANCHOR_RD: begin
        cmd.rd_anchor = 1'b1;
        state_nxt     = ST_ANCHOR_LD;
      end
      ST_ANCHOR_LD: begin
        cmd.ld_anchor = 1'b1;
        state_nxt     = ST_CAND;
      end
      ST_CAND: begin
        cmd.ld_cand = 1'b1;
        state_nxt   = ST_BOUND;
      end
      ST_BOUND: begin
        if (st.bound_ok) begin
          cmd.j_clr = 1'b1;
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (st.overlap) begin
          state_nxt = ST_NEXT;
        end else if (st.j_last) begin
          state_nxt = ST_STORE;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_NEXT: begin
        if (!st.k_last) begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_CAND;
        end else if (!st.i_last) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_ANCHOR_RD;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = raa_pkg::STAT_NO_FIT;
          state_nxt    = ST_DONE;
        end
      end
      ST_STORE: begin
        cmd.store    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = raa_pkg::STAT_PLACED;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/raa_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Rectangle table, walk counters, candidate arithmetic and the result register.
// ----------------------------------------------------------------------------
module raa_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  raa_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [raa_pkg::COORD_BITS-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output raa_pkg::out_item_t                  out_data,
  input  raa_pkg::ctrl_cmd_t                  cmd,
  output raa_pkg::dp_status_t                 st
);

  logic [raa_pkg::COORD_BITS-1:0] side_r;
  logic [raa_pkg::COORD_BITS-1:0] req_w_r, req_h_r;
  raa_pkg::entry_t                anchor_r;
  raa_pkg::ext_t                  cand_x_r, cand_y_r;
  raa_pkg::ext_t                  cand_x_nxt, cand_y_nxt;
  logic [raa_pkg::CNT_BITS-1:0]   cnt_r;
  logic [raa_pkg::IDX_BITS-1:0]   i_r, j_r;
  logic [raa_pkg::CAND_BITS-1:0]  k_r;
  raa_pkg::out_item_t             res_r;
  raa_pkg::out_item_t             out_data_r;
  logic                           out_valid_r;

  raa_pkg::entry_t                rd_entry;
  raa_pkg::entry_t                wr_entry;
  logic [raa_pkg::IDX_BITS-1:0]   rd_addr;
  raa_pkg::ext_t                  ax, ay, aw1, ah1, rw, rh;
  raa_pkg::ext_t                  ex, ey, ew1, eh1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= raa_pkg::SIDE_RESET;
    end else if (cfg_valid) begin
      side_r <= cfg_data;
    end
  end

  // Table memory.
  assign rd_addr    = cmd.rd_anchor ? i_r : j_r;
  assign wr_entry.x = cand_x_r[raa_pkg::COORD_BITS-1:0];
  assign wr_entry.y = cand_y_r[raa_pkg::COORD_BITS-1:0];
  assign wr_entry.w = req_w_r;
  assign wr_entry.h = req_h_r;

  raa_ram #(
    .WIDTH (raa_pkg::ENTRY_BITS),
    .DEPTH (raa_pkg::MAX_RECTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (cnt_r[raa_pkg::IDX_BITS-1:0]),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_anchor | cmd.rd_scan),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Candidate corner around the current anchor.
  assign ax  = raa_pkg::to_ext(anchor_r.x);
  assign ay  = raa_pkg::to_ext(anchor_r.y);
  assign aw1 = raa_pkg::to_ext(anchor_r.w) + raa_pkg::ext_t'(1);
  assign ah1 = raa_pkg::to_ext(anchor_r.h) + raa_pkg::ext_t'(1);
  assign rw  = raa_pkg::to_ext(req_w_r);
  assign rh  = raa_pkg::to_ext(req_h_r);

  always_comb begin
    cand_x_nxt = ax;
    cand_y_nxt = ay;
    case (k_r)
      raa_pkg::CAND_RIGHT: begin
        cand_x_nxt = ax + aw1;
        cand_y_nxt = ay;
      end
      raa_pkg::CAND_BELOW: begin
        cand_x_nxt = ax;
        cand_y_nxt = ay + ah1;
      end
      raa_pkg::CAND_LEFT_TOP: begin
        cand_x_nxt = ax - rw;
        cand_y_nxt = ay;
      end
      raa_pkg::CAND_LEFT_BOT: begin
        cand_x_nxt = ax - rw;
        cand_y_nxt = ay + ah1 - rh;
      end
      raa_pkg::CAND_ABOVE_RIGHT: begin
        cand_x_nxt = ax + aw1 - rw;
        cand_y_nxt = ay - rh;
      end
      raa_pkg::CAND_ABOVE_LEFT: begin
        cand_x_nxt = ax;
        cand_y_nxt = ay - rh;
      end
      default: begin
        cand_x_nxt = ax;
        cand_y_nxt = ay;
      end
    endcase
  end

  // Scanned entry with its padding.
  assign ex  = raa_pkg::to_ext(rd_entry.x);
  assign ey  = raa_pkg::to_ext(rd_entry.y);
  assign ew1 = raa_pkg::to_ext(rd_entry.w) + raa_pkg::ext_t'(1);
  assign eh1 = raa_pkg::to_ext(rd_entry.h) + raa_pkg::ext_t'(1);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_w_r <= in_data.req_width;
      req_h_r <= in_data.req_height;
    end
    if (cmd.ld_anchor) begin
      anchor_r <= rd_entry;
    end
    if (cmd.clr_cand) begin
      cand_x_r <= '0;
      cand_y_r <= '0;
    end else if (cmd.ld_cand) begin
      cand_x_r <= cand_x_nxt;
      cand_y_r <= cand_y_nxt;
    end
    if (cmd.set_res) begin
      res_r.status <= cmd.res_code;
      if (cmd.res_code == raa_pkg::STAT_PLACED) begin
        res_r.pos_x <= cand_x_r[raa_pkg::POS_BITS-1:0];
        res_r.pos_y <= cand_y_r[raa_pkg::POS_BITS-1:0];
      end else begin
        res_r.pos_x <= '0;
        res_r.pos_y <= '0;
      end
    end
    if (cmd.push) begin
      out_data_r <= res_r;
    end
  end

  // Control registers: counters, fill count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= raa_pkg::CAND_RIGHT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        cnt_r <= cnt_r + raa_pkg::CNT_BITS'(1);
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + raa_pkg::IDX_BITS'(1);
      end
      if (cmd.j_clr) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + raa_pkg::IDX_BITS'(1);
      end
      if (cmd.ld_anchor) begin
        k_r <= raa_pkg::CAND_RIGHT;
      end else if (cmd.k_inc) begin
        k_r <= k_r + raa_pkg::CAND_BITS'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  assign st.full     = (cnt_r == raa_pkg::CNT_BITS'(raa_pkg::MAX_RECTS));
  assign st.empty    = (cnt_r == '0);
  assign st.bound_ok = !cand_x_r[raa_pkg::EXT_BITS-1] && !cand_y_r[raa_pkg::EXT_BITS-1] &&
                       (cand_x_r + rw <= raa_pkg::to_ext(side_r)) &&
                       (cand_y_r + rh <= raa_pkg::to_ext(side_r));
  assign st.overlap  = (cand_x_r < ex + ew1) && (ex < cand_x_r + rw) &&
                       (cand_y_r < ey + eh1) && (ey < cand_y_r + rh);
  assign st.k_last   = (k_r == raa_pkg::CAND_ABOVE_LEFT);
  assign st.i_last   = ({1'b0, i_r} + raa_pkg::CNT_BITS'(1)) == cnt_r;
  assign st.j_last   = ({1'b0, j_r} + raa_pkg::CNT_BITS'(1)) == cnt_r;
  assign st.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle atlas allocator core testbench
// Runs directed and random placement requests through the allocator under
// random valid and stall gaps and predicts each result from its own copy of
// the placement table, unless a directed row gives it.
// ----------------------------------------------------------------------------
module testbench;
  import raa_pkg::*;

  // The directed rows either write the atlas side or make one request.
  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [COORD_BITS-1:0] a;      // side for a write, width for a request
    logic [COORD_BITS-1:0] b;      // height for a request
    logic                  known;  // result written into the row
    out_item_t             want;
  } stim_row_t;

  localparam int FIELD_MAX  = (1 << COORD_BITS) - 1;
  localparam int LONG_HOLD  = 3000;
  localparam int N_DIRECTED = 23;

  localparam out_item_t AT_ORIGIN  = '{STAT_PLACED, 13'd0, 13'd0};
  localparam out_item_t NO_FIT_RES = '{STAT_NO_FIT, 13'd0, 13'd0};

  // The first request lands at the origin even though it exceeds a side of
  // one. The large side then pushes a corner past 13 bits of coordinate, and
  // the small side of 64 exercises touching edges and zero-size rectangles.
  localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{ROW_CFG, 14'd1,     14'd0,     1'b0, '0},
    '{ROW_REQ, 14'd1,     14'd2,     1'b1, AT_ORIGIN},
    '{ROW_REQ, 14'd1,     14'd1,     1'b1, NO_FIT_RES},
    '{ROW_REQ, 14'd0,     14'd0,     1'b0, '0},
    '{ROW_REQ, 14'd0,     14'd16383, 1'b0, '0},
    '{ROW_CFG, 14'd16383, 14'd0,     1'b0, '0},
    '{ROW_REQ, 14'd8190,  14'd4,     1'b0, '0},
    '{ROW_REQ, 14'd5,     14'd5,     1'b0, '0},
    '{ROW_REQ, 14'd16383, 14'd1,     1'b0, '0},
    '{ROW_REQ, 14'd16383, 14'd16383, 1'b1, NO_FIT_RES},
    '{ROW_CFG, 14'd8192,  14'd0,     1'b0, '0},
    '{ROW_REQ, 14'd8192,  14'd1,     1'b0, '0},
    '{ROW_REQ, 14'd3,     14'd8192,  1'b0, '0},
    '{ROW_CFG, 14'd64,    14'd0,     1'b0, '0},
    '{ROW_REQ, 14'd10,    14'd10,    1'b0, '0},
    '{ROW_REQ, 14'd10,    14'd10,    1'b0, '0},
    '{ROW_REQ, 14'd64,    14'd1,     1'b0, '0},
    '{ROW_REQ, 14'd20,    14'd6,     1'b0, '0},
    '{ROW_REQ, 14'd1,     14'd64,    1'b0, '0},
    '{ROW_REQ, 14'd0,     14'd5,     1'b0, '0},
    '{ROW_REQ, 14'd65,    14'd1,     1'b1, NO_FIT_RES},
    '{ROW_REQ, 14'd7,     14'd3,     1'b0, '0},
    '{ROW_REQ, 14'd8191,  14'd8191,  1'b1, NO_FIT_RES}
  };

  // Random phases: small atlases keep the table short, since the search time
  // grows with the square of the number of stored rectangles.
  localparam int N_PHASES       = 4;
  localparam int PRESSURE_PHASE = 1;
  localparam int PHASE_SIDE  [N_PHASES] = '{96, 1, 160, 1024};
  localparam int PHASE_ITEMS [N_PHASES] = '{45, 12, 45, 15};
  localparam int PHASE_LO    [N_PHASES] = '{4, 0, 6, 32};
  localparam int PHASE_HI    [N_PHASES] = '{40, 3, 48, 300};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COORD_BITS-1:0] cfg_data;

  // Predicted table: padded boxes in insertion order, plus the atlas side.
  int placed_x [MAX_RECTS];
  int placed_y [MAX_RECTS];
  int placed_w [MAX_RECTS];
  int placed_h [MAX_RECTS];
  int placed_cnt;
  int model_side;

  out_item_t pending_placements [$];
  int        mismatches;
  longint    cycle_cnt;
  longint    cycle_budget;
  bit        idle_on;
  bit        hold_request;

  rect_atlas_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Walks the stored boxes in insertion order and tries the six corners
  // around each one; the first corner inside the atlas that strictly overlaps
  // no stored box wins and is stored with one unit of padding.
  function automatic out_item_t place_rect(input in_item_t req);
    int                   w;
    int                   h;
    int                   cx;
    int                   cy;
    bit                   ok;
    logic [CAND_BITS-1:0] corner;
    out_item_t            res;
    w = req.req_width;
    h = req.req_height;
    res = '{STAT_PLACED, 13'd0, 13'd0};
    if (placed_cnt >= MAX_RECTS) begin
      res.status = STAT_FULL;
      return res;
    end
    if (placed_cnt == 0) begin
      placed_x[0] = 0;
      placed_y[0] = 0;
      placed_w[0] = w + 1;
      placed_h[0] = h + 1;
      placed_cnt = 1;
      return res;
    end
    for (int i = 0; i < placed_cnt; i++) begin
      for (int k = 0; k < 6; k++) begin
        corner = CAND_BITS'(k);
        case (corner)
          CAND_RIGHT: begin
            cx = placed_x[i] + placed_w[i];
            cy = placed_y[i];
          end
          CAND_BELOW: begin
            cx = placed_x[i];
            cy = placed_y[i] + placed_h[i];
          end
          CAND_LEFT_TOP: begin
            cx = placed_x[i] - w;
            cy = placed_y[i];
          end
          CAND_LEFT_BOT: begin
            cx = placed_x[i] - w;
            cy = placed_y[i] + placed_h[i] - h;
          end
          CAND_ABOVE_RIGHT: begin
            cx = placed_x[i] + placed_w[i] - w;
            cy = placed_y[i] - h;
          end
          default: begin
            cx = placed_x[i];
            cy = placed_y[i] - h;
          end
        endcase
        ok = cx >= 0 && cy >= 0 && cx + w <= model_side && cy + h <= model_side;
        for (int j = 0; j < placed_cnt && ok; j++) begin
          if (cx < placed_x[j] + placed_w[j] && placed_x[j] < cx + w &&
              cy < placed_y[j] + placed_h[j] && placed_y[j] < cy + h)
            ok = 1'b0;
        end
        if (ok) begin
          placed_x[placed_cnt] = cx;
          placed_y[placed_cnt] = cy;
          placed_w[placed_cnt] = w + 1;
          placed_h[placed_cnt] = h + 1;
          placed_cnt++;
          res.pos_x = cx[POS_BITS-1:0];
          res.pos_y = cy[POS_BITS-1:0];
          return res;
        end
      end
    end
    res.status = STAT_NO_FIT;
    return res;
  endfunction

  // Mostly sizes from the phase range; some cover the whole field, some are
  // zero or one unit on a side.
  function automatic in_item_t random_request(input int lo, input int hi);
    in_item_t r;
    int       pick;
    pick = $urandom_range(0, 19);
    r.req_width  = COORD_BITS'($urandom_range(lo, hi));
    r.req_height = COORD_BITS'($urandom_range(lo, hi));
    if (pick < 2) begin
      r.req_width  = COORD_BITS'($urandom_range(0, FIELD_MAX));
      r.req_height = COORD_BITS'($urandom_range(0, FIELD_MAX));
    end else if (pick == 2) begin
      if ($urandom_range(0, 1) == 1) r.req_width = '0;
      else r.req_height = '0;
    end else if (pick == 3) begin
      r.req_width = 14'd1;
    end else if (pick == 4) begin
      r.req_height = 14'd1;
    end
    return r;
  endfunction

  // Offers one request, optionally after an idle burst, and records what the
  // block should answer once the item has been taken.
  task automatic request_rect(input in_item_t req, input bit known,
                              input out_item_t want);
    int        gap;
    out_item_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    // Worst-case search time for this table size, plus room for both sides'
    // gaps; the watchdog scales this up.
    cycle_budget += 20 * placed_cnt + 12 * placed_cnt * placed_cnt + 80;
    predicted = place_rect(req);
    if (known) predicted = want;
    pending_placements = {pending_placements, predicted};
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  // The side is only changed once every outstanding result has come back.
  task automatic write_side(input int value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value[COORD_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    model_side = int'(cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side pacing. A long hold, counted here, lets the block fill up
  // and push back on its input; otherwise short random stall bursts.
  initial begin : result_pacing
    int burst;
    int hold_left;
    burst     = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) hold_left--;
      else if (burst > 0) burst--;
      else if (idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 19);
      out_stall = (hold_left > 0) || (burst > 0);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_placements.size() == 0) begin
        $error("unexpected result: status %0d, pos_x %0d, pos_y %0d",
               out_data.status, out_data.pos_x, out_data.pos_y);
        mismatches++;
      end else begin
        want = pending_placements.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.pos_x !== want.pos_x) begin
          $error("pos_x mismatch: expected %0d, actual %0d", want.pos_x, out_data.pos_x);
          mismatches++;
        end
        if (out_data.pos_y !== want.pos_y) begin
          $error("pos_y mismatch: expected %0d, actual %0d", want.pos_y, out_data.pos_y);
          mismatches++;
        end
      end
    end
  end

  // The limit follows the work handed to the block, so a hang on any item
  // ends the run.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > 4 * cycle_budget + 100000) begin
      $display("rect_atlas_allocator_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t req;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    placed_cnt   = 0;
    model_side   = int'(SIDE_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        write_side(int'(DIRECTED_ROWS[r].a));
      end else begin
        req.req_width  = DIRECTED_ROWS[r].a;
        req.req_height = DIRECTED_ROWS[r].b;
        request_rect(req, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_side(PHASE_SIDE[p]);
      if (p == PRESSURE_PHASE) begin
        hold_request = 1'b1;
        cycle_budget += LONG_HOLD;
      end
      repeat (PHASE_ITEMS[p])
        request_rect(random_request(PHASE_LO[p], PHASE_HI[p]), 1'b0, '0);
    end

    // Last stretch runs without gaps on either side.
    drain_results();
    idle_on = 1'b0;
    repeat (8) request_rect(random_request(4, 64), 1'b0, '0);

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("rect_atlas_allocator_core test passed");
    end else begin
      $display("rect_atlas_allocator_core test failed");
    end
    $finish;
  end

endmodule
